/* rtl/rms_dbfs_level_meter_assert.svh */
// assertion macros for the level meter, sampled on clk and idle while arst_n is low
`ifndef RMS_DBFS_LEVEL_METER_ASSERT_SVH
`define RMS_DBFS_LEVEL_METER_ASSERT_SVH

// same-cycle implication
`define RDLM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdlm: same-cycle check failed");

// next-cycle implication
`define RDLM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdlm: next-cycle check failed");

`endif

/* rtl/rdlm_pkg.sv */
package rdlm_pkg;

	localparam int unsigned MAX_FRAME_DEF   = 512;
	localparam int unsigned SAMPLE_W        = 24;
	localparam int unsigned LEVEL_W         = 12;
	localparam int unsigned FRAME_SAMPLES_W = 10;
	localparam int unsigned SILENCE_W       = 23;
	localparam int unsigned CFG_DATA_W      = 23;
	localparam int unsigned CFG_INDEX_W     = 1;
	localparam int unsigned MUL_W           = 32;
	localparam int unsigned FRAC_BITS       = 16;
	localparam int unsigned FRAC_CNT_W      = $clog2(FRAC_BITS);
	// a full-scale magnitude of 2^23 squared
	localparam int unsigned SQUARE_W        = 47;
	// multiplicand of the wide multiply by the frame length
	localparam int unsigned WIDE_W          = 47;
	localparam int unsigned K_W             = 22;

	// (2^23 - 1)^2, full scale power
	localparam logic [WIDE_W-1:0] FS_SQUARED = 47'd70368727400449;
	// 16 * 10 * log10(2) in Q16
	localparam logic [K_W-1:0] LEVEL_K = 22'd3156528;
	localparam logic [63:0] ROUND_BIAS = 64'h0000_0000_7FFF_FFFF;
	localparam logic [LEVEL_W-1:0] LEVEL_MAG_MAX = 12'd2048;

	localparam logic [SILENCE_W-1:0] SILENCE_RST = 23'd16;
	localparam logic signed [LEVEL_W-1:0] FLOOR_RST = -12'sd1440;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SILENCE_RMS = 1'b0,
		REG_FLOOR_LEVEL = 1'b1
	} reg_index_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ,
		ST_ACC,
		ST_THR_SQ,
		ST_THR_LD,
		ST_WLO,
		ST_WHI,
		ST_WSUM,
		ST_CHK,
		ST_LOAD,
		ST_NORM,
		ST_MLD,
		ST_FMUL,
		ST_FUPD,
		ST_LOGD,
		ST_SCALE,
		ST_ROUND,
		ST_EMIT
	} state_t;

	typedef struct packed {
		state_t state;
		logic   phase;
		logic   which;
	} ctrl_t;

	typedef struct packed {
		logic accept;
		logic close;
		logic silent;
		logic d_neg;
		logic norm_last;
		logic out_free;
	} stat_t;

endpackage

/* rtl/rdlm_in_if.sv */
interface rdlm_in_if;
	logic valid;
	logic ready;
	logic signed [rdlm_pkg::SAMPLE_W-1:0] sample;
	logic frame_end;

	modport source (output valid, output sample, output frame_end, input ready);
	modport sink (input valid, input sample, input frame_end, output ready);
endinterface

/* rtl/rdlm_out_if.sv */
interface rdlm_out_if;
	logic valid;
	logic ready;
	logic signed [rdlm_pkg::LEVEL_W-1:0] level_db;
	logic [rdlm_pkg::FRAME_SAMPLES_W-1:0] frame_samples;
	logic silent;

	modport source (output valid, output level_db, output frame_samples, output silent,
		input ready);
	modport sink (input valid, input level_db, input frame_samples, input silent,
		output ready);
endinterface

/* rtl/rdlm_mul.sv */
module rdlm_mul (
	input  logic                            clk,
	input  logic [rdlm_pkg::MUL_W-1:0]      a,
	input  logic [rdlm_pkg::MUL_W-1:0]      b,
	output logic [2*rdlm_pkg::MUL_W-1:0]    prod
);

	logic [2*rdlm_pkg::MUL_W-1:0] full;
	logic [2*rdlm_pkg::MUL_W-1:0] prod_q;

	assign full = a * b;

	always_ff @(posedge clk) begin
		prod_q <= full;
	end

	assign prod = prod_q;

endmodule

/* rtl/rdlm_seq.sv */
module rdlm_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  rdlm_pkg::stat_t stat,
	output rdlm_pkg::ctrl_t ctrl
);

	rdlm_pkg::state_t state_q, state_d;
	logic phase_q, phase_d;
	logic which_q, which_d;
	logic [rdlm_pkg::FRAC_CNT_W-1:0] fit_q, fit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdlm_pkg::ST_IDLE;
			phase_q <= 1'b0;
			which_q <= 1'b0;
			fit_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			which_q <= which_d;
			fit_q   <= fit_d;
		end
	end

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		which_d = which_q;
		fit_d   = fit_q;
		case (state_q)
			rdlm_pkg::ST_IDLE: begin
				if (stat.accept) state_d = rdlm_pkg::ST_SQ;
			end
			rdlm_pkg::ST_SQ: state_d = rdlm_pkg::ST_ACC;
			rdlm_pkg::ST_ACC: begin
				state_d = stat.close ? rdlm_pkg::ST_THR_SQ : rdlm_pkg::ST_IDLE;
			end
			rdlm_pkg::ST_THR_SQ: begin
				phase_d = 1'b0;
				state_d = rdlm_pkg::ST_THR_LD;
			end
			rdlm_pkg::ST_THR_LD: state_d = rdlm_pkg::ST_WLO;
			rdlm_pkg::ST_WLO:    state_d = rdlm_pkg::ST_WHI;
			rdlm_pkg::ST_WHI:    state_d = rdlm_pkg::ST_WSUM;
			rdlm_pkg::ST_WSUM:   state_d = rdlm_pkg::ST_CHK;
			rdlm_pkg::ST_CHK: begin
				if (!phase_q) begin
					if (stat.silent) begin
						state_d = rdlm_pkg::ST_EMIT;
					end else begin
						phase_d = 1'b1;
						state_d = rdlm_pkg::ST_WLO;
					end
				end else begin
					which_d = 1'b0;
					state_d = rdlm_pkg::ST_LOAD;
				end
			end
			rdlm_pkg::ST_LOAD: state_d = rdlm_pkg::ST_NORM;
			rdlm_pkg::ST_NORM: begin
				if (stat.norm_last) state_d = rdlm_pkg::ST_MLD;
			end
			rdlm_pkg::ST_MLD: begin
				fit_d   = '0;
				state_d = rdlm_pkg::ST_FMUL;
			end
			rdlm_pkg::ST_FMUL: state_d = rdlm_pkg::ST_FUPD;
			rdlm_pkg::ST_FUPD: begin
				if (fit_q == rdlm_pkg::FRAC_CNT_W'(rdlm_pkg::FRAC_BITS - 1)) begin
					fit_d   = '0;
					state_d = rdlm_pkg::ST_LOGD;
				end else begin
					fit_d   = fit_q + 1'b1;
					state_d = rdlm_pkg::ST_FMUL;
				end
			end
			rdlm_pkg::ST_LOGD: begin
				if (!which_q) begin
					which_d = 1'b1;
					state_d = rdlm_pkg::ST_LOAD;
				end else begin
					state_d = rdlm_pkg::ST_SCALE;
				end
			end
			rdlm_pkg::ST_SCALE: begin
				state_d = stat.d_neg ? rdlm_pkg::ST_ROUND : rdlm_pkg::ST_EMIT;
			end
			rdlm_pkg::ST_ROUND: state_d = rdlm_pkg::ST_EMIT;
			rdlm_pkg::ST_EMIT: begin
				if (stat.out_free) state_d = rdlm_pkg::ST_IDLE;
			end
			default: state_d = rdlm_pkg::ST_IDLE;
		endcase
	end

	assign ctrl.state = state_q;
	assign ctrl.phase = phase_q;
	assign ctrl.which = which_q;

endmodule

/* rtl/rms_dbfs_level_meter.sv */
// RMS level meter for signed 24-bit audio. Samples arrive one beat at a time on the audio
// channel; each is squared and added to a running sum while a sample counter advances. A
// frame closes on a beat with frame_end set or when the counter reaches MAX_FRAME, and one
// beat then leaves on the meter channel: the level 10*log10(mean square / full scale^2) in
// 1/16 dB steps (0 dBFS is 24-bit full scale, results clipped to -2048..0), the number of
// samples in the frame, and a silent flag. When the RMS is at or below silence_rms the
// frame is silent and level_db carries floor_level as written. All arithmetic runs on a
// single registered 32x32 multiplier under a small sequencer, and the block takes no new
// sample while it works: an ordinary sample is squared and added, a sample that closes a
// frame also forms silence_rms^2 times n for the silence check, and a frame with signal
// then forms full scale^2 times n and takes the two base-2 logarithms (each a normalising
// shift of one step per cycle, then 16 squarings through the multiplier). A finished result
// sits in the output register, so the next frame is collected while it waits; only the
// close of that next frame stalls until the meter beat is taken. Configuration registers:
// index 0 silence_rms (reset 16), index 1 floor_level (reset -1440).
`include "rms_dbfs_level_meter_assert.svh"

module rms_dbfs_level_meter #(
	parameter int unsigned MAX_FRAME = rdlm_pkg::MAX_FRAME_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rdlm_in_if.sink                             audio,
	rdlm_out_if.source                          meter,
	input  logic                                cfg_we,
	input  logic [rdlm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rdlm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// counter holds MAX_FRAME itself
	localparam int unsigned N_W   = $clog2(MAX_FRAME + 1);
	// sum of MAX_FRAME full-scale squares
	localparam int unsigned SUM_W = rdlm_pkg::SQUARE_W + $clog2(MAX_FRAME);
	// log argument: the sum or the full-scale power times n, both fit SUM_W
	localparam int unsigned LOG_W = SUM_W;
	localparam int unsigned E_W   = $clog2(LOG_W);
	localparam int unsigned L2_W  = E_W + rdlm_pkg::FRAC_BITS;
	localparam int unsigned D_W   = L2_W + 1;
	localparam int unsigned LO_W  = rdlm_pkg::MUL_W + N_W;
	localparam int unsigned MW    = rdlm_pkg::MUL_W;
	localparam int unsigned LW    = rdlm_pkg::LEVEL_W;

	rdlm_pkg::ctrl_t ctrl;
	rdlm_pkg::stat_t stat;

	// configuration
	logic [rdlm_pkg::SILENCE_W-1:0] silence_q;
	logic signed [LW-1:0]           floor_q;

	// accumulation
	logic [rdlm_pkg::SAMPLE_W-1:0]  mag;
	logic [rdlm_pkg::SAMPLE_W-1:0]  mag_q;
	logic                           last_q;
	logic [SUM_W-1:0]               sum_q;
	logic [N_W-1:0]                 cnt_q;
	logic [N_W-1:0]                 cnt_next;

	// wide multiply by n and the silence check
	logic [rdlm_pkg::WIDE_W-1:0]    x_q;
	logic [LO_W-1:0]                lo_q;
	logic [SUM_W-1:0]               w_q;
	logic                           silent_q;

	// logarithm
	logic [LOG_W-1:0]               v_q;
	logic [LOG_W-1:0]               shifted;
	logic                           top_zero;
	logic [E_W-1:0]                 amt_q;
	logic [E_W-1:0]                 e_q;
	logic [30:0]                    m_q;
	logic [31:0]                    sq;
	logic [rdlm_pkg::FRAC_BITS-1:0] frac_q;
	logic [L2_W-1:0]                l2s_q;
	logic signed [D_W-1:0]          d_q;
	logic [D_W-1:0]                 dmag;

	// scaling and rounding
	logic [63:0]                    rnd;
	logic [LW-1:0]                  mag_clip;
	logic [LW-1:0]                  level_q;

	// result register
	logic                           ovld_q;
	logic signed [LW-1:0]           lvl_out_q;
	logic [rdlm_pkg::FRAME_SAMPLES_W-1:0] fs_out_q;
	logic                           sil_out_q;

	// shared multiplier
	logic [MW-1:0]                  mul_a;
	logic [MW-1:0]                  mul_b;
	logic [2*MW-1:0]                prod;

	rdlm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	rdlm_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// the block takes a sample only between frames of work
	assign audio.ready = (ctrl.state == rdlm_pkg::ST_IDLE);

	// magnitude of the sample; the most negative code gives 2^23
	assign mag = audio.sample[rdlm_pkg::SAMPLE_W-1] ? (~audio.sample + 1'b1) : audio.sample;

	assign cnt_next = cnt_q + 1'b1;

	// one normalising step: shift by amt_q if the top amt_q bits are clear
	assign shifted  = v_q << amt_q;
	assign top_zero = ((shifted >> amt_q) == v_q);

	// squared mantissa back to Q30
	assign sq = prod[61:30];

	assign dmag = -d_q;

	// round the Q32 magnitude, halves toward zero magnitude, and clip
	assign rnd      = prod + rdlm_pkg::ROUND_BIAS;
	assign mag_clip = (rnd[63:32] > 32'(rdlm_pkg::LEVEL_MAG_MAX)) ?
		rdlm_pkg::LEVEL_MAG_MAX : rnd[32+LW-1:32];

	assign stat.accept    = audio.valid && audio.ready;
	assign stat.close     = last_q || (cnt_next == N_W'(MAX_FRAME));
	assign stat.silent    = (sum_q <= w_q);
	assign stat.d_neg     = d_q[D_W-1];
	assign stat.norm_last = (amt_q == E_W'(1));
	assign stat.out_free  = !ovld_q || meter.ready;

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.state)
			rdlm_pkg::ST_SQ: begin
				mul_a = MW'(mag_q);
				mul_b = MW'(mag_q);
			end
			rdlm_pkg::ST_THR_SQ: begin
				mul_a = MW'(silence_q);
				mul_b = MW'(silence_q);
			end
			rdlm_pkg::ST_WLO: begin
				mul_a = x_q[MW-1:0];
				mul_b = MW'(cnt_q);
			end
			rdlm_pkg::ST_WHI: begin
				mul_a = MW'(x_q[rdlm_pkg::WIDE_W-1:MW]);
				mul_b = MW'(cnt_q);
			end
			rdlm_pkg::ST_FMUL: begin
				mul_a = MW'(m_q);
				mul_b = MW'(m_q);
			end
			rdlm_pkg::ST_SCALE: begin
				mul_a = MW'(dmag);
				mul_b = MW'(rdlm_pkg::LEVEL_K);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// configuration, frame state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_q <= rdlm_pkg::SILENCE_RST;
			floor_q   <= rdlm_pkg::FLOOR_RST;
			sum_q     <= '0;
			cnt_q     <= '0;
			ovld_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rdlm_pkg::REG_SILENCE_RMS: silence_q <= cfg_data;
					rdlm_pkg::REG_FLOOR_LEVEL: floor_q <= cfg_data[LW-1:0];
					default: ;
				endcase
			end
			// a new result takes the register as the old beat leaves
			if (ctrl.state == rdlm_pkg::ST_EMIT && stat.out_free) begin
				ovld_q <= 1'b1;
			end else if (meter.valid && meter.ready) begin
				ovld_q <= 1'b0;
			end
			case (ctrl.state)
				rdlm_pkg::ST_ACC: begin
					sum_q <= sum_q + SUM_W'(prod[rdlm_pkg::SQUARE_W-1:0]);
					cnt_q <= cnt_next;
				end
				rdlm_pkg::ST_EMIT: begin
					// result leaves, frame state starts afresh
					if (stat.out_free) begin
						sum_q  <= '0;
						cnt_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (ctrl.state)
			rdlm_pkg::ST_IDLE: begin
				if (stat.accept) begin
					mag_q  <= mag;
					last_q <= audio.frame_end;
				end
			end
			// silence_rms^2 becomes the multiplicand for the threshold
			rdlm_pkg::ST_THR_LD: x_q <= prod[rdlm_pkg::WIDE_W-1:0];
			rdlm_pkg::ST_WHI:    lo_q <= prod[LO_W-1:0];
			rdlm_pkg::ST_WSUM: begin
				w_q <= SUM_W'(lo_q) + {prod[SUM_W-MW-1:0], {MW{1'b0}}};
			end
			rdlm_pkg::ST_CHK: begin
				// first pass gives the threshold, second the full-scale power
				if (!ctrl.phase) begin
					silent_q <= stat.silent;
					x_q      <= rdlm_pkg::FS_SQUARED;
				end
			end
			rdlm_pkg::ST_LOAD: begin
				v_q    <= ctrl.which ? w_q : sum_q;
				e_q    <= E_W'(LOG_W - 1);
				amt_q  <= E_W'(1 << (E_W - 1));
				frac_q <= '0;
			end
			rdlm_pkg::ST_NORM: begin
				if (top_zero) begin
					v_q <= shifted;
					e_q <= e_q - amt_q;
				end
				amt_q <= amt_q >> 1;
			end
			// mantissa with its top bit at bit 30
			rdlm_pkg::ST_MLD: m_q <= v_q[LOG_W-1 -: 31];
			rdlm_pkg::ST_FUPD: begin
				if (sq[31]) begin
					m_q    <= sq[31:1];
					frac_q <= {frac_q[rdlm_pkg::FRAC_BITS-2:0], 1'b1};
				end else begin
					m_q    <= sq[30:0];
					frac_q <= {frac_q[rdlm_pkg::FRAC_BITS-2:0], 1'b0};
				end
			end
			rdlm_pkg::ST_LOGD: begin
				if (!ctrl.which) begin
					l2s_q <= {e_q, frac_q};
				end else begin
					d_q <= $signed({1'b0, l2s_q}) - $signed({1'b0, e_q, frac_q});
				end
			end
			// at or above full scale reads as 0 dB
			rdlm_pkg::ST_SCALE: begin
				if (!d_q[D_W-1]) level_q <= '0;
			end
			rdlm_pkg::ST_ROUND: level_q <= LW'(0) - mag_clip;
			rdlm_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					lvl_out_q <= silent_q ? floor_q : $signed(level_q);
					fs_out_q  <= rdlm_pkg::FRAME_SAMPLES_W'(cnt_q);
					sil_out_q <= silent_q;
				end
			end
			default: ;
		endcase
	end

	assign meter.valid         = ovld_q;
	assign meter.level_db      = lvl_out_q;
	assign meter.frame_samples = fs_out_q;
	assign meter.silent        = sil_out_q;

	// a sample is never taken into a frame that is already full
	`RDLM_ASSERT_IMP(a_accept_below_max, audio.valid && audio.ready, cnt_q < N_W'(MAX_FRAME))
	// a silent frame reports the floor register
	`RDLM_ASSERT_IMP(a_silent_floor, meter.valid && meter.silent, meter.level_db == floor_q)
	// a measured level never rises above full scale
	`RDLM_ASSERT_IMP(a_level_range, meter.valid && !meter.silent,
		meter.level_db[LW-1] || meter.level_db == '0)
	// emitting a result starts a fresh frame and shows the beat
	`RDLM_ASSERT_NXT(a_emit_clears, ctrl.state == rdlm_pkg::ST_EMIT && stat.out_free,
		cnt_q == '0 && meter.valid)

endmodule

/* test/rms_dbfs_level_meter_test.sv */
module rms_dbfs_level_meter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rdlm_pkg::*;

	// frame length cap used both for the instance and for the predictor
	localparam int unsigned FRAME_CAP = MAX_FRAME_DEF;
	// (2^23 - 1)^2, the power of a full-scale sample
	localparam logic [63:0] FULL_SCALE_POWER = 64'd70368727400449;
	// 16 * 10 * log10(2) in Q16, turns a Q16 log2 ratio into 1/16 dB in Q32
	localparam longint DB16_PER_OCTAVE = 64'sd3156528;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_end;
	} audio_beat_t;

	typedef struct {
		logic signed [LEVEL_W-1:0]  level_db;
		logic [FRAME_SAMPLES_W-1:0] frame_samples;
		logic                       silent;
	} meter_beat_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rdlm_in_if  audio_ch ();
	rdlm_out_if meter_ch ();

	rms_dbfs_level_meter #(
		.MAX_FRAME(FRAME_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.audio    (audio_ch),
		.meter    (meter_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// samples waiting to be offered, and meter beats the predictor still owes
	audio_beat_t audio_backlog[$];
	meter_beat_t expected_levels[$];

	// predictor copy of the registers and of the open frame
	logic [SILENCE_W-1:0] silence_reg;
	logic [LEVEL_W-1:0]   floor_reg;
	logic [63:0]          power_sum;
	int unsigned          open_count;

	// idling odds per side: 0 means no idling, else a burst starts one time in n
	int unsigned idle_odds;
	int unsigned stall_odds;
	int unsigned send_gap;
	int unsigned stall_left;
	int unsigned mismatch_count;
	audio_beat_t next_beat;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// reset once at the start; the configuration inputs get a known value at time zero,
	// the channel signals are set by their own processes while reset is held
	initial begin
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SILENCE_RMS;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// generous fixed limit, well past the slowest legal run
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Q16 base-2 logarithm of a positive integer: top bit index, then 16 squarings
	// of a mantissa held with its top bit at bit 30
	function automatic longint fixed_log2(input logic [63:0] x);
		int     e;
		logic [63:0] m;
		longint frac;
		e = 63;
		frac = 0;
		while (e > 0 && x[e] == 1'b0)
			e--;
		if (e >= 30)
			m = x >> (e - 30);
		else
			m = x << (30 - e);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				frac = frac | 1;
				m = m >> 1;
			end
		end
		return longint'(e) * 65536 + frac;
	endfunction

	// frame level in 1/16 dBFS, clipped to -2048..0, halves rounded up
	function automatic logic signed [LEVEL_W-1:0] frame_dbfs16(input logic [63:0] sum,
		input int unsigned n);
		longint d;
		longint p;
		logic [63:0] q;
		logic [63:0] mag;
		d = fixed_log2(sum) - fixed_log2(64'(n) * FULL_SCALE_POWER);
		p = d * DB16_PER_OCTAVE;
		if (p >= 0)
			return '0;
		q = 64'(-p);
		mag = (q + 64'h7FFF_FFFF) >> 32;
		if (mag > 64'd2048)
			mag = 64'd2048;
		return LEVEL_W'(64'd0 - mag);
	endfunction

	// adds one accepted sample to the open frame and, on a close, queues the meter beat
	task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] sample,
		input logic frame_end);
		logic [63:0] mag;
		logic [63:0] thr;
		meter_beat_t beat;
		mag = sample[SAMPLE_W-1] ? 64'(-longint'(sample)) : 64'(longint'(sample));
		power_sum = power_sum + mag * mag;
		open_count++;
		if (!frame_end && open_count < FRAME_CAP)
			return;
		// silent exactly when rms <= silence_rms, kept in integers
		thr = 64'(silence_reg) * 64'(silence_reg) * 64'(open_count);
		beat.silent = (power_sum <= thr);
		beat.level_db = beat.silent ? floor_reg : frame_dbfs16(power_sum, open_count);
		beat.frame_samples = FRAME_SAMPLES_W'(open_count);
		expected_levels.push_back(beat);
		power_sum = '0;
		open_count = 0;
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 100)
			$display("%t mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_meter_beat();
		meter_beat_t want;
		if (expected_levels.size() == 0) begin
			report_mismatch($sformatf("meter beat with nothing expected (level %0d, n %0d)",
				meter_ch.level_db, meter_ch.frame_samples));
			return;
		end
		want = expected_levels.pop_front();
		if (meter_ch.level_db !== want.level_db)
			report_mismatch($sformatf("level_db %0d, expected %0d",
				meter_ch.level_db, want.level_db));
		if (meter_ch.frame_samples !== want.frame_samples)
			report_mismatch($sformatf("frame_samples %0d, expected %0d",
				meter_ch.frame_samples, want.frame_samples));
		if (meter_ch.silent !== want.silent)
			report_mismatch($sformatf("silent %0b, expected %0b",
				meter_ch.silent, want.silent));
	endtask

	// audio driver: predicts on each accepted beat, then offers the next sample
	// once the current one is gone; gaps only fall between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_ch.valid <= 1'b0;
			audio_ch.sample <= '0;
			audio_ch.frame_end <= 1'b0;
			send_gap = 0;
		end else begin
			if (audio_ch.valid && audio_ch.ready)
				accumulate_sample(audio_ch.sample, audio_ch.frame_end);
			if (!audio_ch.valid || audio_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					audio_ch.valid <= 1'b0;
				end else if (audio_backlog.size() > 0) begin
					next_beat = audio_backlog.pop_front();
					audio_ch.valid <= 1'b1;
					audio_ch.sample <= next_beat.sample;
					audio_ch.frame_end <= next_beat.frame_end;
					// now and then an idle burst of random length follows this beat
					if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
						send_gap = $urandom_range(1, 10);
				end else begin
					audio_ch.valid <= 1'b0;
				end
			end
		end
	end

	// meter monitor: checks every accepted beat, stalls ready in bursts of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (meter_ch.valid && meter_ch.ready)
				check_meter_beat();
			if (stall_left > 0) begin
				stall_left--;
				meter_ch.ready <= 1'b0;
			end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				stall_left = $urandom_range(0, 9);
				meter_ch.ready <= 1'b0;
			end else begin
				meter_ch.ready <= 1'b1;
			end
		end
	end

	// register write while the block is idle; the predictor copy follows it
	task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_SILENCE_RMS: silence_reg = data[SILENCE_W-1:0];
			REG_FLOOR_LEVEL: floor_reg = data[LEVEL_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] sample, input logic last);
		audio_beat_t beat;
		beat.sample = sample;
		beat.frame_end = last;
		audio_backlog.push_back(beat);
	endtask

	// sender holds off until the backlog is gone and every meter beat has come,
	// then waits on so that a sample that closed nothing is fully absorbed
	task automatic drain();
		do
			@(negedge clk);
		while (audio_backlog.size() != 0 || audio_ch.valid || expected_levels.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// random sample scaled down by shift; a shift past the top bit gives silence,
	// and now and then an extreme value turns up
	function automatic logic signed [SAMPLE_W-1:0] rand_sample(input int unsigned shift);
		logic signed [SAMPLE_W-1:0] s;
		if (shift >= SAMPLE_W)
			return '0;
		s = SAMPLE_W'($urandom);
		if ($urandom_range(0, 31) == 0) begin
			case ($urandom_range(0, 3))
				0: s = 24'sh800000;
				1: s = 24'sh7FFFFF;
				2: s = '0;
				default: s = -24'sd1;
			endcase
		end else begin
			s = s >>> shift;
		end
		return s;
	endfunction

	task automatic push_frame(input int unsigned len, input int unsigned shift,
		input bit closed);
		for (int unsigned i = 0; i < len; i++)
			push_sample(rand_sample(shift), closed && i == len - 1);
	endtask

	// frames of mixed length and loudness, each closed by frame_end
	task automatic random_frames(input int unsigned budget);
		int unsigned len;
		int unsigned shift;
		while (budget > 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: len = $urandom_range(1, 8);
				6, 7, 8: len = $urandom_range(9, 64);
				default: len = $urandom_range(65, 200);
			endcase
			if (len > budget)
				len = budget;
			case ($urandom_range(0, 15))
				0: shift = SAMPLE_W;
				1, 2, 3: shift = $urandom_range(16, 23);
				default: shift = $urandom_range(0, 15);
			endcase
			push_frame(len, shift, 1'b1);
			budget -= len;
		end
	endtask

	initial begin
		logic [SILENCE_W-1:0] silence_pick;
		logic [LEVEL_W-1:0] floor_pick;

		mismatch_count = 0;
		silence_reg = SILENCE_RST;
		floor_reg = FLOOR_RST;
		power_sum = '0;
		open_count = 0;
		idle_odds = 6;
		stall_odds = 5;
		@(posedge arst_n);
		@(posedge clk);

		// reset register values: full scale, above full scale, all-zero frame,
		// rms exactly at the threshold, just above it, alternating bit patterns
		push_sample(24'sh7FFFFF, 1'b1);
		push_sample(24'sh800000, 1'b1);
		push_sample('0, 1'b1);
		push_sample(24'sd16, 1'b0);
		push_sample(-24'sd16, 1'b0);
		push_sample(24'sd16, 1'b0);
		push_sample(-24'sd16, 1'b1);
		push_sample(24'sd17, 1'b1);
		push_sample(24'sh555555, 1'b0);
		push_sample(24'shAAAAAA, 1'b1);
		drain();

		// no threshold: a single lsb falls below the level range, zero stays silent,
		// floor holds a positive value outside its range, upper data bits set
		write_register(REG_SILENCE_RMS, '0);
		write_register(REG_FLOOR_LEVEL, {11'h7FF, 12'h7FF});
		push_sample(24'sd1, 1'b1);
		push_sample('0, 1'b1);
		push_sample(-24'sd1, 1'b0);
		push_sample('0, 1'b1);
		drain();

		// top threshold: only a negative full-scale sample gets above it
		write_register(REG_SILENCE_RMS, 23'h7FFFFF);
		write_register(REG_FLOOR_LEVEL, 23'h000800);
		push_sample(24'sh7FFFFF, 1'b1);
		push_sample(24'sh800000, 1'b0);
		push_sample(24'sh7FFFFF, 1'b1);
		push_sample(24'sh800000, 1'b1);
		drain();

		// random part: a fresh register setting per phase, a full-length frame that
		// closes by itself in one phase, and a last phase with no idling at all
		for (int r = 0; r < 6; r++) begin
			if (r == 0) begin
				silence_pick = SILENCE_RST;
				floor_pick = '0;
			end else begin
				case ($urandom_range(0, 3))
					0: silence_pick = '0;
					1: silence_pick = SILENCE_W'($urandom_range(0, 64));
					2: silence_pick = SILENCE_W'($urandom) >> $urandom_range(0, 22);
					default: silence_pick = 23'h7FFFFF;
				endcase
				if ($urandom_range(0, 3) == 0)
					floor_pick = LEVEL_W'($urandom);
				else
					floor_pick = LEVEL_W'(-$urandom_range(0, 2048));
			end
			write_register(REG_SILENCE_RMS, silence_pick);
			write_register(REG_FLOOR_LEVEL, {11'($urandom), floor_pick});
			if (r == 5) begin
				idle_odds = 0;
				stall_odds = 0;
			end else begin
				idle_odds = (r == 1) ? 0 : $urandom_range(2, 10);
				stall_odds = (r == 3) ? 0 : $urandom_range(2, 10);
			end
			if (r == 2) begin
				// runs past the cap with no frame_end, a few samples carry over
				push_frame(FRAME_CAP + 3, $urandom_range(4, 20), 1'b0);
				random_frames(20);
			end else begin
				random_frames(40);
			end
			drain();
		end

		// room for a stray beat after the last expected one
		repeat (150) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
